// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by line_sensor_centroid.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, quiet during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, quiet during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Sizes, codes and helpers of the line sensor centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

	localparam int CHANNELS    = 4;
	localparam int SAMPLE_BITS = 12;
	localparam int CFG_W       = 12;
	localparam int LEVEL_W     = 10;
	localparam int POS_W       = 12;
	localparam int LEVEL_MAX   = 1000;
	localparam int WEIGHT_STEP = 1000;

	localparam int CH_W    = $clog2(CHANNELS);
	localparam int W_MAX   = (WEIGHT_STEP / 2) * (CHANNELS - 1);
	localparam int W_W     = $clog2(W_MAX + 1) + 1;
	localparam int ACC_W   = LEVEL_W + W_W + CH_W;
	localparam int PROD_W  = SAMPLE_BITS + LEVEL_W;
	localparam int DIV_W   = (PROD_W > ACC_W) ? PROD_W : ACC_W;
	localparam int DEN_W   = $clog2(LEVEL_MAX * CHANNELS + 1);
	localparam int RAW_MAX_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
	localparam int DSR_W   = (RAW_MAX_W > DEN_W) ? RAW_MAX_W : DEN_W;
	localparam int RNG_W   = RAW_MAX_W + 1;
	localparam int CMP_W   = (DEN_W > CFG_W) ? DEN_W : CFG_W;
	localparam int CNT_W   = $clog2(DIV_W);

	localparam int IN_DATA_W   = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((POS_W + CHANNELS * LEVEL_W + 7) / 8) * 8;
	localparam int IN_USER_W   = 2;
	localparam int OUT_USER_W  = 1;
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

	typedef enum logic [1:0] {
		MODE_POS,
		MODE_SAMPLE,
		MODE_CLEAR,
		MODE_FINISH
	} mode_t;

	typedef enum logic [1:0] {
		REG_INVERT,
		REG_LOST_THR,
		REG_MIN_RANGE,
		REG_MIN_SPAN
	} reg_idx_t;

	function automatic logic signed [W_W-1:0] channel_weight(input logic [CH_W-1:0] i);
		logic signed [W_W-1:0] w;
		w = W_W'(WEIGHT_STEP * int'(i) - W_MAX);
		return w;
	endfunction

endpackage

`default_nettype wire

// File: src/line_sensor_centroid.sv
// ----------------------------------------------------------------------------
// line_sensor_centroid
// Calibrated reflectance line sensor: per-channel window, scaling, centroid.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per sensor scan: four raw samples in s_tdata and the
//   mode in s_tuser (position, calibration sample, clear, finish).
//   m_* returns one word per input word: position and levels in m_tdata, the
//   lost flag in m_tuser.
//   The APB port writes and reads invert, lost_threshold, min_range, min_span.
// Timing:
//   A position word runs a scaling division per channel and one centroid
//   division through one shared radix-2 restoring divider (DIV_W = 24 steps
//   each). A sample at or below its minimum skips its division; a lost line
//   skips the centroid division. A calibration word goes to the output
//   register without any division. s_tready returns with m_tvalid, so a word
//   is accepted only after the previous result has loaded.
// Reset:
//   arst_n restores register defaults, a cleared window in every channel,
//   position 0 and lost 0. A stalled result holds in the output register; the
//   next word may be accepted meanwhile and waits before its result loads.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_centroid
	import lsc_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,

	input  wire                    s_tvalid,
	output logic                   s_tready,
	// sample_a, sample_b, sample_c, sample_d
	input  wire  [IN_DATA_W-1:0]   s_tdata,
	// mode
	input  wire  [IN_USER_W-1:0]   s_tuser,

	output logic                   m_tvalid,
	input  wire                    m_tready,
	// line_position, level_a, level_b, level_c, level_d, zero pad
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// line_lost
	output logic [OUT_USER_W-1:0]  m_tuser,

	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire  [APB_ADDR_W-1:0]  paddr,
	input  wire  [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NSET,
		ST_DIV,
		ST_NDONE,
		ST_ACC,
		ST_CENT,
		ST_CDONE,
		ST_DONE
	} state_t;

	state_t                       state_q;
	logic                         cent_q;
	logic [SAMPLE_BITS-1:0]       samp_q [CHANNELS];
	logic [SAMPLE_BITS-1:0]       low_q  [CHANNELS];
	logic [SAMPLE_BITS-1:0]       high_q [CHANNELS];
	logic [LEVEL_W-1:0]           lvl_q  [CHANNELS];
	logic signed [ACC_W-1:0]      num_q;
	logic [DEN_W-1:0]             den_q;
	logic [CH_W-1:0]              idx_q;
	logic [DSR_W-1:0]             rem_q;
	logic [DIV_W-1:0]             dvd_q;
	logic [DSR_W-1:0]             dsr_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         neg_q;
	logic signed [POS_W-1:0]      held_q;
	logic                         lost_q;
	logic                         m_tvalid_q;
	logic [OUT_DATA_W-1:0]        m_tdata_q;
	logic [OUT_USER_W-1:0]        m_tuser_q;

	logic                         invert_q;
	logic [CFG_W-1:0]             lost_thr_q;
	logic [CFG_W-1:0]             min_range_q;
	logic [CFG_W-1:0]             min_span_q;

	logic [SAMPLE_BITS-1:0]       in_raw [CHANNELS];
	mode_t                        in_mode;
	logic                         in_acc;

	logic [SAMPLE_BITS-1:0]       cur_low;
	logic [SAMPLE_BITS-1:0]       cur_high;
	logic [SAMPLE_BITS-1:0]       cur_raw;
	logic signed [RNG_W-1:0]      rng;
	logic [CFG_W-1:0]             flr;
	logic signed [RNG_W-1:0]      flr_s;
	logic [RNG_W-1:0]             range_eff;
	logic [PROD_W-1:0]            prod;

	logic [DSR_W:0]               trial;
	logic                         ge;
	logic [DSR_W-1:0]             rem_nxt;

	logic [LEVEL_W-1:0]           lvl_clamp;
	logic [LEVEL_W-1:0]           lvl_new;
	logic signed [LEVEL_W+W_W:0]  term;
	logic [ACC_W-1:0]             num_abs;
	logic [POS_W-1:0]             pos_mag;
	logic                         is_lost;
	logic [OUT_DATA_W-1:0]        out_data;

	reg_idx_t                     reg_sel;

	// ------------------------------------------------------------------
	// input unpacking
	// ------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			in_raw[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	assign in_mode  = mode_t'(s_tuser[1:0]);
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// per-channel scaling setup
	// ------------------------------------------------------------------
	assign cur_low   = low_q[idx_q];
	assign cur_high  = high_q[idx_q];
	assign cur_raw   = samp_q[idx_q];
	assign rng       = signed'(RNG_W'(cur_high)) - signed'(RNG_W'(cur_low));
	assign flr       = (min_range_q == '0) ? CFG_W'(1) : min_range_q;
	assign flr_s     = signed'(RNG_W'(flr));
	assign range_eff = (rng < flr_s) ? unsigned'(flr_s) : unsigned'(rng);
	assign prod      = PROD_W'(cur_raw - cur_low) * PROD_W'(LEVEL_MAX);

	// ------------------------------------------------------------------
	// shared divider step
	// ------------------------------------------------------------------
	assign trial   = {rem_q, dvd_q[DIV_W-1]};
	assign ge      = (trial >= {1'b0, dsr_q});
	assign rem_nxt = ge ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];

	// ------------------------------------------------------------------
	// level, centroid term, result
	// ------------------------------------------------------------------
	assign lvl_clamp = (dvd_q > DIV_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : dvd_q[LEVEL_W-1:0];
	assign lvl_new   = invert_q ? LEVEL_W'(LEVEL_MAX) - lvl_clamp : lvl_clamp;
	assign term      = signed'({1'b0, lvl_q[idx_q]}) * channel_weight(idx_q);
	assign num_abs   = (num_q < 0) ? unsigned'(-num_q) : unsigned'(num_q);
	assign pos_mag   = dvd_q[POS_W-1:0];
	assign is_lost   = (den_q == '0) || (CMP_W'(den_q) < CMP_W'(lost_thr_q));

	always_comb begin
		out_data = '0;
		out_data[POS_W-1:0] = held_q;
		for (int i = 0; i < CHANNELS; i++) begin
			out_data[POS_W + i*LEVEL_W +: LEVEL_W] = lvl_q[i];
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cent_q     <= 1'b0;
			num_q      <= '0;
			den_q      <= '0;
			idx_q      <= '0;
			rem_q      <= '0;
			dvd_q      <= '0;
			dsr_q      <= '0;
			cnt_q      <= '0;
			neg_q      <= 1'b0;
			held_q     <= '0;
			lost_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				samp_q[i] <= '0;
				low_q[i]  <= FULL_SCALE;
				high_q[i] <= '0;
				lvl_q[i]  <= '0;
			end
		end else begin
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						for (int i = 0; i < CHANNELS; i++) begin
							samp_q[i] <= in_raw[i];
							lvl_q[i]  <= '0;
						end
						idx_q <= '0;
						num_q <= '0;
						den_q <= '0;
						unique case (in_mode)
							MODE_POS: begin
								state_q <= ST_NSET;
							end
							MODE_SAMPLE: begin
								for (int i = 0; i < CHANNELS; i++) begin
									if (in_raw[i] < low_q[i]) begin
										low_q[i] <= in_raw[i];
									end
									if (in_raw[i] > high_q[i]) begin
										high_q[i] <= in_raw[i];
									end
								end
								state_q <= ST_DONE;
							end
							MODE_CLEAR: begin
								for (int i = 0; i < CHANNELS; i++) begin
									low_q[i]  <= FULL_SCALE;
									high_q[i] <= '0;
								end
								state_q <= ST_DONE;
							end
							MODE_FINISH: begin
								for (int i = 0; i < CHANNELS; i++) begin
									if ((signed'(RNG_W'(high_q[i])) - signed'(RNG_W'(low_q[i])))
											< signed'(RNG_W'(min_span_q))) begin
										low_q[i]  <= '0;
										high_q[i] <= FULL_SCALE;
									end
								end
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_NSET: begin
					rem_q  <= '0;
					cnt_q  <= CNT_W'(DIV_W - 1);
					cent_q <= 1'b0;
					dsr_q  <= DSR_W'(range_eff);
					if (cur_raw <= cur_low) begin
						dvd_q   <= '0;
						state_q <= ST_NDONE;
					end else begin
						dvd_q   <= DIV_W'(prod);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_nxt;
					dvd_q <= {dvd_q[DIV_W-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= cent_q ? ST_CDONE : ST_NDONE;
					end
				end
				ST_NDONE: begin
					lvl_q[idx_q] <= lvl_new;
					state_q      <= ST_ACC;
				end
				ST_ACC: begin
					num_q <= num_q + ACC_W'(term);
					den_q <= den_q + DEN_W'(lvl_q[idx_q]);
					if (idx_q == CH_W'(CHANNELS - 1)) begin
						state_q <= ST_CENT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_NSET;
					end
				end
				ST_CENT: begin
					rem_q  <= '0;
					cnt_q  <= CNT_W'(DIV_W - 1);
					cent_q <= 1'b1;
					dsr_q  <= DSR_W'(den_q);
					dvd_q  <= DIV_W'(num_abs);
					neg_q  <= (num_q < 0);
					if (is_lost) begin
						lost_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						lost_q  <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_CDONE: begin
					held_q  <= signed'(neg_q ? POS_W'('0 - pos_mag) : pos_mag);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= out_data;
						m_tuser_q  <= OUT_USER_W'(lost_q);
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q    <= 1'b0;
			lost_thr_q  <= CFG_W'(200);
			min_range_q <= CFG_W'(50);
			min_span_q  <= CFG_W'(100);
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_INVERT:    invert_q    <= pwdata[0];
				REG_LOST_THR:  lost_thr_q  <= pwdata[CFG_W-1:0];
				REG_MIN_RANGE: min_range_q <= pwdata[CFG_W-1:0];
				REG_MIN_SPAN:  min_span_q  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_INVERT:    prdata = APB_DATA_W'(invert_q);
			REG_LOST_THR:  prdata = APB_DATA_W'(lost_thr_q);
			REG_MIN_RANGE: prdata = APB_DATA_W'(min_range_q);
			REG_MIN_SPAN:  prdata = APB_DATA_W'(min_span_q);
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
`include "assert_macros.svh"

	`ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`ASSERT_IMPL(a_div_nonzero, state_q == ST_DIV, dsr_q != '0, "divide by zero")
	`ASSERT_IMPL(a_rem_below, state_q == ST_DIV, rem_q < dsr_q, "remainder out of range")
	`ASSERT_IMPL(a_level_max, state_q == ST_ACC, lvl_q[idx_q] <= LEVEL_W'(LEVEL_MAX), "level over max")

endmodule

`default_nettype wire
